FILE: rtl/core/hcn_pkg.sv
// Shared constants, types and tables of the hit cylindrical normalizer.
// Used by every module of the block; depends on nothing.
package hcn_pkg;

    localparam int MAX_ROWS_DEF      = 64;
    localparam int CORDIC_STAGES_DEF = 18;
    localparam int ROW_CAP           = 64;
    localparam int QUEUE_DEPTH       = 2;

    localparam int COORD_W     = 24;
    localparam int SCALE_W     = 48;
    localparam int ROWS_W      = 7;
    localparam int ROW_INDEX_W = 6;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_INV_RADIUS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INV_LENGTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ROWS   = 2'd2;

    localparam logic [ROWS_W-1:0]  MAX_ROWS_RESET = 7'd64;
    localparam logic [31:0]        INV_GAIN_Q32   = 32'h9B74EDA8;

    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [ROW_INDEX_W-1:0]    row_index;
        logic                      last_row;
        logic                      y_zero;
        logic                      x_neg;
    } hcn_item_t;

endpackage

FILE: rtl/core/hit_cylindrical_normalizer.sv
// A hit waits in the queue until the back end is idle; the back end then runs the
// iterative CORDIC (one stage a cycle) and the eight steps of the shared scaling
// multiplier, one hit at a time, and holds the row until the output register is free.
// A two-entry queue lets the front take hits while the back end works.
// Reset is asynchronous, active low: row counter, queue, sequencer and output
// valid clear; inv_radius and inv_length return to 0, max_rows to 64.
module hit_cylindrical_normalizer #(
    parameter int MAX_ROWS      = hcn_pkg::MAX_ROWS_DEF,
    parameter int CORDIC_STAGES = hcn_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [hcn_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [hcn_pkg::SCALE_W-1:0]           cfg_data,
    input  logic                                  hit_valid,
    output logic                                  hit_stall,
    input  logic signed [hcn_pkg::COORD_W-1:0]    hit_x,
    input  logic signed [hcn_pkg::COORD_W-1:0]    hit_y,
    input  logic signed [hcn_pkg::COORD_W-1:0]    hit_z,
    input  logic                                  last_hit,
    output logic                                  row_valid,
    input  logic                                  row_stall,
    output logic [16:0]                           norm_radius,
    output logic signed [16:0]                    norm_angle,
    output logic signed [17:0]                    norm_height,
    output logic [hcn_pkg::ROW_INDEX_W-1:0]       row_index,
    output logic                                  last_row
);

    logic [hcn_pkg::SCALE_W-1:0] inv_radius_reg;
    logic [hcn_pkg::SCALE_W-1:0] inv_length_reg;
    logic [hcn_pkg::ROWS_W-1:0]  max_rows_reg;
    logic                        cfg_write;

    logic                        q_push;
    logic                        q_pop;
    logic                        q_full;
    logic                        q_empty;
    hcn_pkg::hcn_item_t          push_item;
    hcn_pkg::hcn_item_t          pop_item;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_radius_reg <= '0;
            inv_length_reg <= '0;
            max_rows_reg   <= hcn_pkg::MAX_ROWS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                hcn_pkg::CFG_INV_RADIUS: inv_radius_reg <= cfg_data;
                hcn_pkg::CFG_INV_LENGTH: inv_length_reg <= cfg_data;
                hcn_pkg::CFG_MAX_ROWS:   max_rows_reg   <= cfg_data[hcn_pkg::ROWS_W-1:0];
                default:                 max_rows_reg   <= max_rows_reg;
            endcase
        end
    end

    hcn_front #(
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .hit_valid (hit_valid),
        .hit_stall (hit_stall),
        .hit_x     (hit_x),
        .hit_y     (hit_y),
        .hit_z     (hit_z),
        .last_hit  (last_hit),
        .max_rows  (max_rows_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    hcn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    hcn_back #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .q_item      (pop_item),
        .inv_radius  (inv_radius_reg),
        .inv_length  (inv_length_reg),
        .row_valid   (row_valid),
        .row_stall   (row_stall),
        .norm_radius (norm_radius),
        .norm_angle  (norm_angle),
        .norm_height (norm_height),
        .row_index   (row_index),
        .last_row    (last_row)
    );

endmodule

FILE: rtl/core/hcn_front.sv
// Front end: accepts hits, applies the per-event row limit and numbers rows.
// Depends on hcn_pkg; feeds hcn_queue.
module hcn_front #(
    parameter int MAX_ROWS = hcn_pkg::MAX_ROWS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                hit_valid,
    output logic                                hit_stall,
    input  logic signed [hcn_pkg::COORD_W-1:0]  hit_x,
    input  logic signed [hcn_pkg::COORD_W-1:0]  hit_y,
    input  logic signed [hcn_pkg::COORD_W-1:0]  hit_z,
    input  logic                                last_hit,
    input  logic [hcn_pkg::ROWS_W-1:0]          max_rows,
    input  logic                                q_full,
    output logic                                q_push,
    output hcn_pkg::hcn_item_t                  q_item
);

    localparam int CAP = (MAX_ROWS < hcn_pkg::ROW_CAP) ? MAX_ROWS : hcn_pkg::ROW_CAP;
    localparam logic [hcn_pkg::ROWS_W-1:0] CAP_ROWS = hcn_pkg::ROWS_W'(CAP);

    logic [hcn_pkg::ROWS_W-1:0] rows_done_reg;
    logic [hcn_pkg::ROWS_W-1:0] rows_done_next;
    logic [hcn_pkg::ROWS_W-1:0] limit;
    logic                       accept;
    logic                       keep;

    always_comb
    begin
        limit = max_rows;
        if (limit == '0)
        begin
            limit = hcn_pkg::ROWS_W'(1);
        end
        if (limit > CAP_ROWS)
        begin
            limit = CAP_ROWS;
        end
    end

    assign hit_stall = q_full;
    assign accept    = hit_valid & ~q_full;
    assign keep      = rows_done_reg < limit;
    assign q_push    = accept & keep;

    always_comb
    begin
        rows_done_next = rows_done_reg;
        if (accept)
        begin
            if (last_hit)
            begin
                rows_done_next = '0;
            end
            else if (keep)
            begin
                rows_done_next = rows_done_reg + hcn_pkg::ROWS_W'(1);
            end
        end
    end

    always_comb
    begin
        q_item.x         = hit_x;
        q_item.y         = hit_y;
        q_item.z         = hit_z;
        q_item.row_index = rows_done_reg[hcn_pkg::ROW_INDEX_W-1:0];
        q_item.last_row  = last_hit | (rows_done_reg == (limit - hcn_pkg::ROWS_W'(1)));
        q_item.y_zero    = (hit_y == '0);
        q_item.x_neg     = hit_x[hcn_pkg::COORD_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_done_reg <= '0;
        end
        else
        begin
            rows_done_reg <= rows_done_next;
        end
    end

endmodule

FILE: rtl/core/hcn_queue.sv
// Short first-in first-out queue of classified hits between front and back end.
// Depends on hcn_pkg for the item type and depth.
module hcn_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hcn_pkg::hcn_item_t push_item,
    output logic               full,
    input  logic               pop,
    output hcn_pkg::hcn_item_t pop_item,
    output logic               empty
);

    localparam int DEPTH = hcn_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hcn_pkg::hcn_item_t   slot_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push & ~full;
    assign do_pop   = pop & ~empty;
    assign pop_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/core/hcn_back.sv
// Back end: iterative CORDIC vectoring, a shared multiplier for the scaling
// products, rounding and saturation, and the output register. Depends on hcn_pkg.
module hcn_back #(
    parameter int CORDIC_STAGES = hcn_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   q_empty,
    output logic                                   q_pop,
    input  hcn_pkg::hcn_item_t                     q_item,
    input  logic [hcn_pkg::SCALE_W-1:0]            inv_radius,
    input  logic [hcn_pkg::SCALE_W-1:0]            inv_length,
    output logic                                   row_valid,
    input  logic                                   row_stall,
    output logic [16:0]                            norm_radius,
    output logic signed [16:0]                     norm_angle,
    output logic signed [17:0]                     norm_height,
    output logic [hcn_pkg::ROW_INDEX_W-1:0]        row_index,
    output logic                                   last_row
);

    localparam int STAGE_W = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
    localparam int VEC_W   = 27;
    localparam int ACC_W   = 34;
    localparam int RAD_W   = 107;
    localparam int HGT_W   = 73;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_ROTATE = 2'd1;
    localparam logic [1:0] ST_MUL    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic [2:0] MS_GAIN   = 3'd0;
    localparam logic [2:0] MS_HGT_LO = 3'd1;
    localparam logic [2:0] MS_HGT_HI = 3'd2;
    localparam logic [2:0] MS_RAD_LL = 3'd3;
    localparam logic [2:0] MS_RAD_LH = 3'd4;
    localparam logic [2:0] MS_RAD_HL = 3'd5;
    localparam logic [2:0] MS_RAD_HH = 3'd6;
    localparam logic [2:0] MS_LAST   = 3'd7;

    logic [1:0]                state_reg;
    logic [1:0]                state_next;
    logic [STAGE_W-1:0]        stage_reg;
    logic [STAGE_W-1:0]        stage_next;
    logic [2:0]                step_reg;
    logic [2:0]                step_next;
    logic                      row_valid_reg;
    logic                      row_valid_next;

    hcn_pkg::hcn_item_t        item_reg;
    logic signed [VEC_W-1:0]   cx_reg;
    logic signed [VEC_W-1:0]   cx_next;
    logic signed [VEC_W-1:0]   cy_reg;
    logic signed [VEC_W-1:0]   cy_next;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic [23:0]               mag_reg;
    logic [63:0]               prod_reg;
    logic [57:0]               rq_reg;
    logic [RAD_W-1:0]          rad_acc_reg;
    logic [RAD_W-1:0]          rad_acc_next;
    logic [HGT_W-1:0]          hgt_acc_reg;
    logic [HGT_W-1:0]          hgt_acc_next;

    logic [16:0]               norm_radius_reg;
    logic signed [16:0]        norm_angle_reg;
    logic signed [17:0]        norm_height_reg;
    logic [hcn_pkg::ROW_INDEX_W-1:0] row_index_reg;
    logic                      last_row_reg;

    logic signed [VEC_W-1:0]   xe;
    logic signed [VEC_W-1:0]   ye;
    logic signed [24:0]        ze;
    logic signed [VEC_W-1:0]   sx;
    logic signed [VEC_W-1:0]   sy;
    logic signed [ACC_W-1:0]   atan_step;
    logic [31:0]               mul_a;
    logic [31:0]               mul_b;
    logic                      load;
    logic                      out_free;
    logic                      finish;

    logic signed [ACC_W-1:0]   acc_rnd;
    logic signed [ACC_W-1:0]   ang_sh;
    logic signed [16:0]        ang_val;
    logic [42:0]               rad_hi;
    logic [16:0]               rad_val;
    logic [40:0]               hgt_q;
    logic signed [17:0]        hgt_val;

    assign out_free = ~row_valid_reg | ~row_stall;
    assign load     = (state_reg == ST_IDLE) & ~q_empty;
    assign q_pop    = load;
    assign finish   = (state_reg == ST_FINISH) & out_free;

    assign xe = {{(VEC_W - hcn_pkg::COORD_W){q_item.x[hcn_pkg::COORD_W-1]}}, q_item.x};
    assign ye = {{(VEC_W - hcn_pkg::COORD_W){q_item.y[hcn_pkg::COORD_W-1]}}, q_item.y};
    assign ze = {q_item.z[hcn_pkg::COORD_W-1], q_item.z};

    assign sx        = cx_reg >>> stage_reg;
    assign sy        = cy_reg >>> stage_reg;
    assign atan_step = signed'({2'b00, hcn_pkg::ATAN_TURNS[5'(stage_reg)]});

    always_comb
    begin
        state_next   = state_reg;
        stage_next   = stage_reg;
        step_next    = step_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        acc_next     = acc_reg;
        rad_acc_next = rad_acc_reg;
        hgt_acc_next = hgt_acc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (load)
                begin
                    state_next   = ST_ROTATE;
                    stage_next   = '0;
                    rad_acc_next = RAD_W'(1) << 63;
                    hgt_acc_next = HGT_W'(1) << 31;
                    cx_next      = xe;
                    cy_next      = ye;
                    acc_next     = '0;
                    if (q_item.x_neg)
                    begin
                        if (!q_item.y[hcn_pkg::COORD_W-1])
                        begin
                            cx_next  = ye;
                            cy_next  = -xe;
                            acc_next = ACC_W'(34'sh40000000);
                        end
                        else
                        begin
                            cx_next  = -ye;
                            cy_next  = xe;
                            acc_next = -ACC_W'(34'sh40000000);
                        end
                    end
                end
            end
            ST_ROTATE:
            begin
                if (!cy_reg[VEC_W-1])
                begin
                    cx_next  = cx_reg + sy;
                    cy_next  = cy_reg - sx;
                    acc_next = acc_reg + atan_step;
                end
                else
                begin
                    cx_next  = cx_reg - sy;
                    cy_next  = cy_reg + sx;
                    acc_next = acc_reg - atan_step;
                end
                if (stage_reg == STAGE_W'(CORDIC_STAGES - 1))
                begin
                    state_next = ST_MUL;
                    step_next  = MS_GAIN;
                end
                else
                begin
                    stage_next = stage_reg + STAGE_W'(1);
                end
            end
            ST_MUL:
            begin
                case (step_reg)
                    MS_HGT_HI: hgt_acc_next = hgt_acc_reg + HGT_W'(prod_reg);
                    MS_RAD_LL: hgt_acc_next = hgt_acc_reg + (HGT_W'(prod_reg) << 24);
                    MS_RAD_LH: rad_acc_next = rad_acc_reg + RAD_W'(prod_reg);
                    MS_RAD_HL: rad_acc_next = rad_acc_reg + (RAD_W'(prod_reg) << 24);
                    MS_RAD_HH: rad_acc_next = rad_acc_reg + (RAD_W'(prod_reg) << 29);
                    MS_LAST:   rad_acc_next = rad_acc_reg + (RAD_W'(prod_reg) << 53);
                    default:   rad_acc_next = rad_acc_reg;
                endcase
                if (step_reg == MS_LAST)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            MS_GAIN:
            begin
                if (!(item_reg.y_zero && !item_reg.x_neg && item_reg.x == '0) &&
                    !cx_reg[VEC_W-1])
                begin
                    mul_a = 32'(cx_reg[VEC_W-2:0]);
                end
                mul_b = hcn_pkg::INV_GAIN_Q32;
            end
            MS_HGT_LO:
            begin
                mul_a = 32'(mag_reg);
                mul_b = 32'(inv_length[23:0]);
            end
            MS_HGT_HI:
            begin
                mul_a = 32'(mag_reg);
                mul_b = 32'(inv_length[47:24]);
            end
            MS_RAD_LL:
            begin
                mul_a = 32'(rq_reg[28:0]);
                mul_b = 32'(inv_radius[23:0]);
            end
            MS_RAD_LH:
            begin
                mul_a = 32'(rq_reg[28:0]);
                mul_b = 32'(inv_radius[47:24]);
            end
            MS_RAD_HL:
            begin
                mul_a = 32'(rq_reg[57:29]);
                mul_b = 32'(inv_radius[23:0]);
            end
            MS_RAD_HH:
            begin
                mul_a = 32'(rq_reg[57:29]);
                mul_b = 32'(inv_radius[47:24]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        acc_rnd = acc_reg + ACC_W'(34'sd32768);
        ang_sh  = acc_rnd >>> 16;
        if (item_reg.y_zero)
        begin
            ang_val = item_reg.x_neg ? 17'sd32768 : 17'sd0;
        end
        else if (ang_sh > ACC_W'(34'sd32768))
        begin
            ang_val = 17'sd32768;
        end
        else if (ang_sh < -ACC_W'(34'sd32768))
        begin
            ang_val = -17'sd32768;
        end
        else
        begin
            ang_val = ang_sh[16:0];
        end

        rad_hi  = rad_acc_reg[RAD_W-1:64];
        rad_val = (|rad_hi[42:17]) ? 17'h1FFFF : rad_hi[16:0];

        hgt_q = hgt_acc_reg[HGT_W-1:32];
        if (item_reg.z[hcn_pkg::COORD_W-1])
        begin
            hgt_val = (|hgt_q[40:17]) ? -18'sd131072 : -signed'({1'b0, hgt_q[16:0]});
        end
        else
        begin
            hgt_val = (|hgt_q[40:17]) ? 18'sd131071 : signed'({1'b0, hgt_q[16:0]});
        end
    end

    always_comb
    begin
        row_valid_next = row_valid_reg & row_stall;
        if (finish)
        begin
            row_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            stage_reg     <= '0;
            step_reg      <= MS_GAIN;
            row_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stage_reg     <= stage_next;
            step_reg      <= step_next;
            row_valid_reg <= row_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        acc_reg     <= acc_next;
        rad_acc_reg <= rad_acc_next;
        hgt_acc_reg <= hgt_acc_next;
        prod_reg    <= 64'(mul_a) * 64'(mul_b);
        if (load)
        begin
            item_reg <= q_item;
            mag_reg  <= 24'(ze[24] ? -ze : ze);
        end
        if ((state_reg == ST_MUL) && (step_reg == MS_HGT_LO))
        begin
            rq_reg <= prod_reg[57:0];
        end
        if (finish)
        begin
            norm_radius_reg <= rad_val;
            norm_angle_reg  <= ang_val;
            norm_height_reg <= hgt_val;
            row_index_reg   <= item_reg.row_index;
            last_row_reg    <= item_reg.last_row;
        end
    end

    assign row_valid   = row_valid_reg;
    assign norm_radius = norm_radius_reg;
    assign norm_angle  = norm_angle_reg;
    assign norm_height = norm_height_reg;
    assign row_index   = row_index_reg;
    assign last_row    = last_row_reg;

endmodule

FILE: rtl/core/hcn_checker.sv
// Port-level assertions for hit_cylindrical_normalizer and the bind that attaches them.
// Depends on hcn_pkg for field widths.
module hcn_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              row_valid,
    input logic                              row_stall,
    input logic [16:0]                       norm_radius,
    input logic signed [16:0]                norm_angle,
    input logic signed [17:0]                norm_height,
    input logic [hcn_pkg::ROW_INDEX_W-1:0]   row_index,
    input logic                              last_row
);

    a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && row_stall |=> row_valid && $stable(norm_radius) &&
        $stable(norm_angle) && $stable(norm_height) && $stable(row_index) &&
        $stable(last_row))
        else $error("Row changed during a stalled transfer.");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid |-> (norm_angle >= -17'sd32768) && (norm_angle <= 17'sd32768))
        else $error("Angle outside one half-turn.");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !row_valid)
        else $error("Row offered during reset.");

    a_full_event_last: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && (row_index == 6'd63) |-> last_row)
        else $error("Final row of a full event is not marked last.");

endmodule

bind hit_cylindrical_normalizer hcn_checker u_checker (.*);

FILE: tb/sv/tb_top.sv
// Self-checking testbench of hit_cylindrical_normalizer: a directed table, then random
// events under changing scale and row-limit settings and idling patterns.
// Depends on hcn_pkg and the hit_cylindrical_normalizer RTL only.
module tb_top;

    localparam int COORD_W           = hcn_pkg::COORD_W;
    localparam int SCALE_W           = hcn_pkg::SCALE_W;
    localparam int ROWS_W            = hcn_pkg::ROWS_W;
    localparam int ROW_INDEX_W       = hcn_pkg::ROW_INDEX_W;
    localparam int CFG_INDEX_W       = hcn_pkg::CFG_INDEX_W;
    localparam int MAX_ROWS_DEF      = hcn_pkg::MAX_ROWS_DEF;
    localparam int ROW_CAP           = hcn_pkg::ROW_CAP;
    localparam logic [CFG_INDEX_W-1:0] CFG_INV_RADIUS = hcn_pkg::CFG_INV_RADIUS;
    localparam logic [CFG_INDEX_W-1:0] CFG_INV_LENGTH = hcn_pkg::CFG_INV_LENGTH;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ROWS   = hcn_pkg::CFG_MAX_ROWS;
    localparam logic [ROWS_W-1:0]      MAX_ROWS_RESET = hcn_pkg::MAX_ROWS_RESET;

    localparam int STAGES        = hcn_pkg::CORDIC_STAGES_DEF;
    localparam int SETTLE_CYCLES = hcn_pkg::CORDIC_STAGES_DEF + 20;
    localparam int PHASES        = 12;
    localparam int HITS_PER_PHASE = 111;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [31:0] ARC_STEP [STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F
    };

    typedef struct {
        logic [16:0]        radius;
        logic signed [16:0] angle;
        logic signed [17:0] height;
        logic [5:0]         idx;
        logic               last;
    } feature_row_t;

    typedef enum { STEP_HIT, STEP_CFG } step_kind_t;

    typedef struct {
        step_kind_t kind;
        longint     a;
        longint     b;
        longint     c;
        bit         d;
        bit         typed;
        int         e_radius;
        int         e_angle;
        int         e_height;
        int         e_idx;
        bit         e_last;
    } dir_step_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b1;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [CFG_INDEX_W-1:0]         cfg_index = '0;
    logic [SCALE_W-1:0]             cfg_data = '0;
    logic                           hit_valid = 1'b0;
    logic                           hit_stall;
    logic signed [COORD_W-1:0]      hit_x = '0;
    logic signed [COORD_W-1:0]      hit_y = '0;
    logic signed [COORD_W-1:0]      hit_z = '0;
    logic                           last_hit = 1'b0;
    logic                           row_valid;
    logic                           row_stall = 1'b0;
    logic [16:0]                    norm_radius;
    logic signed [16:0]             norm_angle;
    logic signed [17:0]             norm_height;
    logic [ROW_INDEX_W-1:0]         row_index;
    logic                           last_row;

    logic [SCALE_W-1:0] inv_radius_q = '0;
    logic [SCALE_W-1:0] inv_length_q = '0;
    logic [ROWS_W-1:0]  max_rows_q = MAX_ROWS_RESET;
    int                 rows_in_event = 0;

    feature_row_t expected_rows [$];
    int           mismatches = 0;
    int           send_idle_pct = 0;
    int           stall_pct = 0;

    dir_step_t directed_steps [28] = '{
        '{STEP_HIT, 0, 0, 0, 1'b0, 1'b1, 0, 0, 0, 0, 1'b0},
        '{STEP_HIT, 8388607, 0, 8388607, 1'b0, 1'b1, 0, 0, 0, 1, 1'b0},
        '{STEP_HIT, -8388608, 0, -8388608, 1'b1, 1'b1, 0, 32768, 0, 2, 1'b1},
        '{STEP_CFG, CFG_INV_RADIUS, 48'hFFFF_FFFF_FFFF, 0, 1'b0, 1'b0, 0, 0, 0, 0, 1'b0},
        '{STEP_CFG, CFG_INV_LENGTH, 48'hFFFF_FFFF_FFFF, 0, 1'b0, 1'b0, 0, 0, 0, 0, 1'b0},
        '{STEP_CFG, CFG_MAX_ROWS, 3, 0, 1'b0, 1'b0, 0, 0, 0, 0, 1'b0},
        '{STEP_HIT, 8388607, 8388607, 8388607, 1'b0, 1'b0, 0, 0, 0, 0, 1'b0},
        '{STEP_HIT, -8388608, -8388608, -8388608, 1'b0, 1'b0, 0, 0, 0, 0, 1'b0},
        '{STEP_HIT, -1, 1, -1, 1'b0, 1'b0, 0, 0, 0, 0, 1'b0},
        '{STEP_HIT, 5, 5, 5, 1'b0, 1'b0, 0, 0, 0, 0, 1'b0},
        '{STEP_HIT, 6, -6, 0, 1'b1, 1'b0, 0, 0, 0, 0, 1'b0},
        '{STEP_HIT, 0, -8388608, 1, 1'b0, 1'b0, 0, 0, 0, 0, 1'b0},
        '{STEP_HIT, -8388608, 8388607, -1, 1'b0, 1'b0, 0, 0, 0, 0, 1'b0},
        '{STEP_CFG, CFG_MAX_ROWS, 0, 0, 1'b0, 1'b0, 0, 0, 0, 0, 1'b0},
        '{STEP_HIT, 1, 0, 2, 1'b0, 1'b0, 0, 0, 0, 0, 1'b0},
        '{STEP_HIT, 2, 0, 3, 1'b1, 1'b0, 0, 0, 0, 0, 1'b0},
        '{STEP_HIT, 3, -4, 4, 1'b0, 1'b0, 0, 0, 0, 0, 1'b0},
        '{STEP_HIT, 4, -3, 5, 1'b1, 1'b0, 0, 0, 0, 0, 1'b0},
        '{STEP_CFG, CFG_UNUSED, 48'h5A5A_A5A5_0F0F, 0, 1'b0, 1'b0, 0, 0, 0, 0, 1'b0},
        '{STEP_CFG, CFG_MAX_ROWS, 48'hABCD_0000_007F, 0, 1'b0, 1'b0, 0, 0, 0, 0, 1'b0},
        '{STEP_CFG, CFG_INV_RADIUS, 48'h0000_0100_0000, 0, 1'b0, 1'b0, 0, 0, 0, 0, 1'b0},
        '{STEP_CFG, CFG_INV_LENGTH, 48'h0000_0100_0000, 0, 1'b0, 1'b0, 0, 0, 0, 0, 1'b0},
        '{STEP_HIT, 8388607, -1, -8388608, 1'b0, 1'b0, 0, 0, 0, 0, 1'b0},
        '{STEP_HIT, -8388608, -1, 8388607, 1'b0, 1'b0, 0, 0, 0, 0, 1'b0},
        '{STEP_HIT, -8388608, 1, -1, 1'b0, 1'b0, 0, 0, 0, 0, 1'b0},
        '{STEP_HIT, 1, -1, 0, 1'b0, 1'b0, 0, 0, 0, 0, 1'b0},
        '{STEP_HIT, -1, 0, 1, 1'b1, 1'b0, 0, 0, 0, 0, 1'b0},
        '{STEP_HIT, 0, 1, -8388608, 1'b1, 1'b0, 0, 0, 0, 0, 1'b0}
    };

    hit_cylindrical_normalizer DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        row_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic int row_limit();
        int lim;
        lim = int'(max_rows_q);
        if (lim < 1)
            lim = 1;
        if (lim > MAX_ROWS_DEF)
            lim = MAX_ROWS_DEF;
        if (lim > ROW_CAP)
            lim = ROW_CAP;
        return lim;
    endfunction

    function automatic bit predict_row(input longint x, input longint y, input longint z,
                                       input bit last, output feature_row_t row);
        longint       cx;
        longint       cy;
        longint       sx;
        longint       sy;
        longint       acc;
        longint       ang;
        longint       nz;
        logic [63:0]  rq;
        logic [63:0]  mag;
        logic [127:0] prod;
        logic [95:0]  q;
        int           lim;
        lim = row_limit();
        if (rows_in_event >= lim)
        begin
            if (last)
                rows_in_event = 0;
            return 1'b0;
        end
        cx = x;
        cy = y;
        acc = 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                cx = y;
                cy = -x;
                acc = 64'sh4000_0000;
            end
            else
            begin
                cx = -y;
                cy = x;
                acc = -64'sh4000_0000;
            end
        end
        for (int i = 0; i < STAGES; i++)
        begin
            sx = cx >>> i;
            sy = cy >>> i;
            if (cy >= 0)
            begin
                cx = cx + sy;
                cy = cy - sx;
                acc = acc + longint'(ARC_STEP[i]);
            end
            else
            begin
                cx = cx - sy;
                cy = cy + sx;
                acc = acc - longint'(ARC_STEP[i]);
            end
        end
        if (x == 0 && y == 0)
        begin
            ang = 0;
            cx = 0;
        end
        else if (y == 0)
            ang = (x < 0) ? 32768 : 0;
        else
        begin
            ang = (acc + 32768) >>> 16;
            if (ang > 32768)
                ang = 32768;
            if (ang < -32768)
                ang = -32768;
        end
        if (cx < 0)
            cx = 0;

        rq = 64'(cx) * 64'h9B74_EDA8;
        prod = 128'(rq) * 128'(inv_radius_q) + (128'h1 << 63);
        row.radius = (prod[127:64] > 64'd131071) ? 17'h1FFFF : prod[80:64];
        row.angle = ang[16:0];

        mag = (z < 0) ? -z : z;
        prod = 128'(mag) * 128'(inv_length_q) + 128'h8000_0000;
        q = prod[127:32];
        if (z < 0)
            nz = (q >= 96'd131072) ? -64'sd131072 : -longint'(q[63:0]);
        else
            nz = (q > 96'd131071) ? 64'sd131071 : longint'(q[63:0]);
        row.height = nz[17:0];
        row.idx = rows_in_event[5:0];
        row.last = last || (rows_in_event == lim - 1);
        rows_in_event = last ? 0 : rows_in_event + 1;
        return 1'b1;
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return 24'($urandom);
            5, 6: return 24'($urandom_range(32)) - 24'd16;
            7:
                case ($urandom_range(3))
                    0: return 24'h7FFFFF;
                    1: return 24'h800000;
                    2: return 24'hFFFFFF;
                    default: return 24'h000001;
                endcase
            8: return '0;
            default: return $signed(24'($urandom)) >>> $urandom_range(20);
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        case ($urandom_range(4))
            0: return '0;
            1: return '1;
            2: return 48'({$urandom, $urandom});
            default: return (48'h1 << 47) / 48'($urandom_range(32'h0080_0000, 32'h0001_0000));
        endcase
    endfunction

    task automatic compare_field(input string name, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : row_monitor
        feature_row_t want;
        if (rst_n && row_valid && !row_stall)
        begin
            if (expected_rows.size() == 0)
            begin
                $error("row transfer with no row expected");
                mismatches++;
            end
            else
            begin
                want = expected_rows.pop_front();
                compare_field("norm_radius", 64'(want.radius), 64'(norm_radius));
                compare_field("norm_angle", 64'(want.angle), 64'(norm_angle));
                compare_field("norm_height", 64'(want.height), 64'(norm_height));
                compare_field("row_index", 64'(want.idx), 64'(row_index));
                compare_field("last_row", 64'(want.last), 64'(last_row));
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [SCALE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_INV_RADIUS: inv_radius_q = data;
            CFG_INV_LENGTH: inv_length_q = data;
            CFG_MAX_ROWS: max_rows_q = data[ROWS_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_hit(input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
                            input logic signed [COORD_W-1:0] z, input bit last,
                            input bit typed, input feature_row_t typed_row);
        feature_row_t row;
        while ($urandom_range(99) < send_idle_pct)
        begin
            hit_valid <= 1'b0;
            @(posedge clk);
        end
        hit_valid <= 1'b1;
        hit_x <= x;
        hit_y <= y;
        hit_z <= z;
        last_hit <= last;
        do
            @(posedge clk);
        while (hit_stall);
        if (predict_row(x, y, z, last, row))
            expected_rows.insert(expected_rows.size(), typed ? typed_row : row);
    endtask

    task automatic drain_rows();
        hit_valid <= 1'b0;
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        #8_000_000;
        $display("hit_cylindrical_normalizer verification failed");
        $finish;
    end

    initial
    begin
        feature_row_t      typed_row;
        bit                last;
        int                ev_len;
        int                ev_pos;
        logic [ROWS_W-1:0] rows_val;
        logic [SCALE_W-1:0] fill;

        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[k])
        begin
            if (directed_steps[k].kind == STEP_CFG)
            begin
                drain_rows();
                write_reg(directed_steps[k].a[CFG_INDEX_W-1:0],
                          directed_steps[k].b[SCALE_W-1:0]);
            end
            else
            begin
                typed_row.radius = 17'(directed_steps[k].e_radius);
                typed_row.angle = 17'(directed_steps[k].e_angle);
                typed_row.height = 18'(directed_steps[k].e_height);
                typed_row.idx = 6'(directed_steps[k].e_idx);
                typed_row.last = directed_steps[k].e_last;
                send_hit(directed_steps[k].a[COORD_W-1:0], directed_steps[k].b[COORD_W-1:0],
                         directed_steps[k].c[COORD_W-1:0], directed_steps[k].d,
                         directed_steps[k].typed, typed_row);
            end
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_rows();
            send_idle_pct = 0;
            stall_pct = 0;
            write_reg(CFG_INV_RADIUS, (phase == 0) ? '1 : (phase == 1) ? '0 : pick_scale());
            write_reg(CFG_INV_LENGTH, (phase == 0) ? '1 : (phase == 1) ? '0 : pick_scale());
            case (phase)
                0: rows_val = 7'd64;
                1: rows_val = 7'd0;
                2: rows_val = 7'd1;
                default:
                    case ($urandom_range(3))
                        0: rows_val = 7'($urandom_range(127));
                        1: rows_val = 7'($urandom_range(8, 1));
                        2: rows_val = 7'd64;
                        default: rows_val = 7'($urandom_range(70, 60));
                    endcase
            endcase
            fill = 48'({$urandom, $urandom});
            write_reg(CFG_MAX_ROWS, {fill[SCALE_W-1:ROWS_W], rows_val});
            if ($urandom_range(3) == 0)
                write_reg(CFG_UNUSED, 48'({$urandom, $urandom}));

            case (phase % 4)
                0: ;
                1: send_idle_pct = 86;
                2: stall_pct = 86;
                default:
                begin
                    send_idle_pct = 12;
                    stall_pct = 12;
                end
            endcase

            ev_pos = 0;
            ev_len = $urandom_range(row_limit() + 4, 1);
            for (int n = 0; n < HITS_PER_PHASE; n++)
            begin
                last = (ev_pos == ev_len - 1) || ($urandom_range(99) < 3);
                send_hit(pick_coord(), pick_coord(), pick_coord(), last, 1'b0, typed_row);
                if (last)
                begin
                    ev_pos = 0;
                    ev_len = $urandom_range(row_limit() + 4, 1);
                end
                else
                    ev_pos++;
            end
        end

        drain_rows();
        if (mismatches == 0)
            $display("hit_cylindrical_normalizer verification clean");
        else
            $display("hit_cylindrical_normalizer verification failed");
        $finish;
    end

endmodule
